>>> rtl/core/deqrm_pkg.sv
`default_nettype none
package deqrm_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    KIND_PUSH_TAIL = 3'd0,
    KIND_PUSH_HEAD = 3'd1,
    KIND_POP_HEAD  = 3'd2,
    KIND_POP_TAIL  = 3'd3,
    KIND_REMOVE    = 3'd4,
    KIND_SEARCH    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_PREV = 2'd2,
    CELL_NEXT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     cmp_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/core/deqrm_cell.sv
`default_nettype none
module deqrm_cell (
  input  wire logic                                     clk,
  input  wire deqrm_pkg::cell_ctrl_t                    ctrl,
  input  wire logic signed [deqrm_pkg::DATA_W-1:0]      load_data,
  input  wire logic signed [deqrm_pkg::DATA_W-1:0]      prev_data,
  input  wire logic signed [deqrm_pkg::DATA_W-1:0]      next_data,
  input  wire logic signed [deqrm_pkg::DATA_W-1:0]      cmp_data,
  output logic signed      [deqrm_pkg::DATA_W-1:0]      entry,
  output logic                                          match
);

  logic signed [deqrm_pkg::DATA_W-1:0] entry_r;
  logic signed [deqrm_pkg::DATA_W-1:0] entry_nxt;
  logic                                match_r;

  always_comb begin
    case (ctrl.op)
      deqrm_pkg::CELL_LOAD: entry_nxt = load_data;
      deqrm_pkg::CELL_PREV: entry_nxt = prev_data;
      deqrm_pkg::CELL_NEXT: entry_nxt = next_data;
      default:              entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctrl.cmp_en) begin
      match_r <= (entry_r == cmp_data);
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule
`default_nettype wire

>>> rtl/core/deque_with_remove_by_value.sv
// Double-ended queue of signed 32-bit values with remove and search by value.
// Requests arrive on the in_ channel (in_kind, in_value) with valid/ready and
// every request produces exactly one result on the out_ channel with status,
// value, position, entry count and empty flag.
// The store is a row of DEPTH cells. Each cell holds one entry, compares it
// against the request value when the request is taken, and on the following
// cycle loads the new value, takes its left or right neighbor, or holds.
// A request is taken in one cycle and executed in the next; the result is
// registered at the end of the executing cycle and held until it is drained.
// The block takes no new request while one is executing, so it cannot start
// a request before the previous one has reached the result register.
// A new request is taken only in the idle state and while the result register
// is empty or being drained in the same cycle, so a stalled receiver holds off the requester.
// Reset empties the store and clears the result valid flag; entry contents are
// not cleared and need not be, since only entries below the count are read.
`default_nettype none
module deque_with_remove_by_value #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          in_kind,
  input  wire logic signed [31:0]  in_value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_status,
  output logic signed [31:0]       out_value,
  output logic [3:0]               out_position,
  output logic [4:0]               out_entry_count,
  output logic                     out_is_empty
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = $clog2(DEPTH);

  deqrm_pkg::state_t state_r;
  deqrm_pkg::state_t state_nxt;

  logic [2:0]                           kind_r;
  logic signed [deqrm_pkg::DATA_W-1:0]  value_r;
  logic [CW-1:0]                        count_r;
  logic [CW-1:0]                        count_nxt;

  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  logic [1:0]                           status_r;
  logic [1:0]                           status_nxt;
  logic signed [deqrm_pkg::DATA_W-1:0]  result_r;
  logic signed [deqrm_pkg::DATA_W-1:0]  result_nxt;
  logic [PW-1:0]                        pos_r;
  logic [PW-1:0]                        pos_nxt;

  logic signed [deqrm_pkg::DATA_W-1:0]  ent [DEPTH];
  logic [DEPTH-1:0]                     match;
  logic [DEPTH-1:0]                     live;
  logic [DEPTH-1:0]                     tail;
  logic [DEPTH-1:0]                     hits;
  logic [DEPTH-1:0]                     below;
  logic [DEPTH-1:0]                     first;
  logic [DEPTH-1:0]                     from_hit;
  logic                                 found;
  logic                                 full;
  logic                                 empty;
  logic                                 take;
  logic [PW-1:0]                        hit_pos;
  logic signed [deqrm_pkg::DATA_W-1:0]  tail_value;
  deqrm_pkg::cell_ctrl_t                ctrl [DEPTH];

  assign take  = in_valid && in_ready;
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live[i] = (count_r > CW'(i));
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      tail[i] = live[i] && !live[i+1];
    end
    tail[DEPTH-1] = live[DEPTH-1];
  end

  assign hits     = match & live;
  assign found    = |hits;
  assign below    = hits - DEPTH'(1);
  assign first    = hits & ~below;
  assign from_hit = ~(hits ^ below) | first;

  always_comb begin
    hit_pos    = '0;
    tail_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_pos    = hit_pos | ({PW{first[i]}} & PW'(i));
      tail_value = tail_value | ({deqrm_pkg::DATA_W{tail[i]}} & ent[i]);
    end
  end

  always_comb begin
    case (state_r)
      deqrm_pkg::ST_IDLE: state_nxt = take ? deqrm_pkg::ST_EXEC : deqrm_pkg::ST_IDLE;
      deqrm_pkg::ST_EXEC: state_nxt = deqrm_pkg::ST_IDLE;
      default:            state_nxt = deqrm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == deqrm_pkg::ST_IDLE) && (!out_valid_r || out_ready);
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].cmp_en = take;
      ctrl[i].op     = deqrm_pkg::CELL_HOLD;
      if (state_r == deqrm_pkg::ST_EXEC) begin
        case (kind_r)
          deqrm_pkg::KIND_PUSH_TAIL: begin
            if (!full && count_r == CW'(i)) begin
              ctrl[i].op = deqrm_pkg::CELL_LOAD;
            end
          end
          deqrm_pkg::KIND_PUSH_HEAD: begin
            if (!full) begin
              ctrl[i].op = (i == 0) ? deqrm_pkg::CELL_LOAD : deqrm_pkg::CELL_PREV;
            end
          end
          deqrm_pkg::KIND_POP_HEAD: begin
            if (!empty) begin
              ctrl[i].op = deqrm_pkg::CELL_NEXT;
            end
          end
          deqrm_pkg::KIND_REMOVE: begin
            if (found && from_hit[i]) begin
              ctrl[i].op = deqrm_pkg::CELL_NEXT;
            end
          end
          default: ctrl[i].op = deqrm_pkg::CELL_HOLD;
        endcase
      end
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = status_r;
    result_nxt = result_r;
    pos_nxt    = pos_r;
    if (state_r == deqrm_pkg::ST_EXEC) begin
      status_nxt = deqrm_pkg::STATUS_OK;
      result_nxt = '0;
      pos_nxt    = '0;
      case (kind_r)
        deqrm_pkg::KIND_PUSH_TAIL, deqrm_pkg::KIND_PUSH_HEAD: begin
          if (full) begin
            status_nxt = deqrm_pkg::STATUS_OVERFLOW;
          end else begin
            result_nxt = value_r;
            count_nxt  = count_r + CW'(1);
          end
        end
        deqrm_pkg::KIND_POP_HEAD, deqrm_pkg::KIND_POP_TAIL: begin
          if (empty) begin
            status_nxt = deqrm_pkg::STATUS_UNDERFLOW;
          end else begin
            result_nxt = (kind_r == deqrm_pkg::KIND_POP_HEAD) ? ent[0] : tail_value;
            count_nxt  = count_r - CW'(1);
          end
        end
        deqrm_pkg::KIND_REMOVE, deqrm_pkg::KIND_SEARCH: begin
          if (!found) begin
            status_nxt = deqrm_pkg::STATUS_NOT_FOUND;
          end else begin
            result_nxt = value_r;
            pos_nxt    = hit_pos;
            if (kind_r == deqrm_pkg::KIND_REMOVE) begin
              count_nxt = count_r - CW'(1);
            end
          end
        end
        default: status_nxt = deqrm_pkg::STATUS_OK;
      endcase
    end
  end

  always_comb begin
    if (state_r == deqrm_pkg::ST_EXEC) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deqrm_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      kind_r  <= in_kind;
      value_r <= in_value;
    end
    status_r <= status_nxt;
    result_r <= result_nxt;
    pos_r    <= pos_nxt;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [deqrm_pkg::DATA_W-1:0] prev_data;
    logic signed [deqrm_pkg::DATA_W-1:0] next_data;

    if (g == 0) begin : g_first
      assign prev_data = ent[g];
    end else begin : g_mid_prev
      assign prev_data = ent[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_data = ent[g];
    end else begin : g_mid_next
      assign next_data = ent[g+1];
    end

    deqrm_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .load_data (value_r),
      .prev_data (prev_data),
      .next_data (next_data),
      .cmp_data  (in_value),
      .entry     (ent[g]),
      .match     (match[g])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_value       = result_r;
  assign out_position    = 4'(pos_r);
  assign out_entry_count = 5'(count_r);
  assign out_is_empty    = empty;

endmodule
`default_nettype wire
